// ===== src/tbs_pkg.sv =====
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared types and codes for the buffered TWI transfer sequencer.
// ----------------------------------------------------------------------------
package tbs_pkg;

  localparam int unsigned TBS_TX_DEPTH = 32;
  localparam int unsigned TBS_RX_DEPTH = 32;

  localparam logic [5:0] CNT_MAX = 6'd63;

  // operation codes
  localparam logic [2:0] OP_LOAD_TX   = 3'd0;
  localparam logic [2:0] OP_START     = 3'd1;
  localparam logic [2:0] OP_SLAVE_LEN = 3'd2;
  localparam logic [2:0] OP_EVENT     = 3'd3;
  localparam logic [2:0] OP_READ_RX   = 3'd4;

  // bus actions
  localparam logic [2:0] ACT_NONE        = 3'd0;
  localparam logic [2:0] ACT_CLEAR       = 3'd1;
  localparam logic [2:0] ACT_START       = 3'd2;
  localparam logic [2:0] ACT_STOP        = 3'd3;
  localparam logic [2:0] ACT_ACK         = 3'd4;
  localparam logic [2:0] ACT_NACK        = 3'd5;
  localparam logic [2:0] ACT_START_QUIET = 3'd6;

  // call status
  localparam logic [1:0] CS_OK    = 2'd0;
  localparam logic [1:0] CS_OVF   = 2'd1;
  localparam logic [1:0] CS_FEWER = 2'd2;
  localparam logic [1:0] CS_MORE  = 2'd3;

  // bus engine status, TWI code shifted right three
  localparam logic [4:0] ST_BUS_ERR      = 5'h00; // 0x00
  localparam logic [4:0] ST_START        = 5'h01; // 0x08
  localparam logic [4:0] ST_REP_START    = 5'h02; // 0x10
  localparam logic [4:0] ST_MT_SLA_ACK   = 5'h03; // 0x18
  localparam logic [4:0] ST_MT_SLA_NACK  = 5'h04; // 0x20
  localparam logic [4:0] ST_MT_DATA_ACK  = 5'h05; // 0x28
  localparam logic [4:0] ST_MT_DATA_NACK = 5'h06; // 0x30
  localparam logic [4:0] ST_ARB_LOST     = 5'h07; // 0x38
  localparam logic [4:0] ST_MR_SLA_ACK   = 5'h08; // 0x40
  localparam logic [4:0] ST_MR_SLA_NACK  = 5'h09; // 0x48
  localparam logic [4:0] ST_MR_DATA_ACK  = 5'h0A; // 0x50
  localparam logic [4:0] ST_MR_DATA_NACK = 5'h0B; // 0x58
  localparam logic [4:0] ST_SR_SLA_ACK   = 5'h0C; // 0x60
  localparam logic [4:0] ST_SR_ARB_SLA   = 5'h0D; // 0x68
  localparam logic [4:0] ST_SR_GEN_ACK   = 5'h0E; // 0x70
  localparam logic [4:0] ST_SR_ARB_GEN   = 5'h0F; // 0x78
  localparam logic [4:0] ST_SR_DATA_ACK  = 5'h10; // 0x80
  localparam logic [4:0] ST_SR_DATA_NACK = 5'h11; // 0x88
  localparam logic [4:0] ST_SR_GDAT_ACK  = 5'h12; // 0x90
  localparam logic [4:0] ST_SR_GDAT_NACK = 5'h13; // 0x98
  localparam logic [4:0] ST_SR_STOP      = 5'h14; // 0xA0
  localparam logic [4:0] ST_ST_SLA_ACK   = 5'h15; // 0xA8
  localparam logic [4:0] ST_ST_ARB_SLA   = 5'h16; // 0xB0
  localparam logic [4:0] ST_ST_DATA_ACK  = 5'h17; // 0xB8
  localparam logic [4:0] ST_ST_DATA_NACK = 5'h18; // 0xC0
  localparam logic [4:0] ST_ST_LAST_ACK  = 5'h19; // 0xC8

  typedef struct packed {
    logic       en;
    logic [5:0] addr;
    logic [7:0] data;
  } tbs_wr_t;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] entry_index;
    logic [7:0] data_in;
    logic [6:0] target_address;
    logic       read_not_write;
    logic [7:0] byte_count;
    logic       send_stop;
    logic [4:0] bus_status;
  } tbs_item_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic       drive_valid;
    logic [7:0] drive_byte;
    logic [1:0] call_status;
    logic [7:0] rx_byte;
    logic [5:0] rx_length;
    logic [4:0] last_error;
    logic       receive_done;
  } tbs_result_t;

  function automatic logic [5:0] sat_inc(input logic [5:0] v);
    return (v < CNT_MAX) ? v + 6'd1 : CNT_MAX;
  endfunction

  function automatic logic [5:0] sat_len(input logic [7:0] c);
    return (c > {2'b00, CNT_MAX}) ? CNT_MAX : c[5:0];
  endfunction

endpackage

// ===== src/tbs_stores.sv =====
// ----------------------------------------------------------------------------
// tbs_stores
// Transmit and receive byte stores; out-of-range writes dropped, reads give 0.
// ----------------------------------------------------------------------------
module tbs_stores
  import tbs_pkg::*;
#(
  parameter int unsigned TX_DEPTH = TBS_TX_DEPTH,
  parameter int unsigned RX_DEPTH = TBS_RX_DEPTH
) (
  input  logic       clk,
  input  tbs_wr_t    tx_wr,
  input  tbs_wr_t    rx_wr,
  input  logic [5:0] tx_rd_pos,
  input  logic [5:0] rx_rd_pos,
  output logic [7:0] tx_rd_data,
  output logic [7:0] rx_rd_data
);

  localparam int unsigned TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int unsigned RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam logic [7:0] TX_LIM = 8'(TX_DEPTH);
  localparam logic [7:0] RX_LIM = 8'(RX_DEPTH);

  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RX_DEPTH];

  logic tx_wr_ok, rx_wr_ok, tx_rd_ok, rx_rd_ok;

  assign tx_wr_ok = {2'b00, tx_wr.addr} < TX_LIM;
  assign rx_wr_ok = {2'b00, rx_wr.addr} < RX_LIM;
  assign tx_rd_ok = {2'b00, tx_rd_pos} < TX_LIM;
  assign rx_rd_ok = {2'b00, rx_rd_pos} < RX_LIM;

  always_ff @(posedge clk) begin
    if (tx_wr.en && tx_wr_ok) begin
      tx_mem[TX_AW'(tx_wr.addr)] <= tx_wr.data;
    end
    if (rx_wr.en && rx_wr_ok) begin
      rx_mem[RX_AW'(rx_wr.addr)] <= rx_wr.data;
    end
  end

  assign tx_rd_data = tx_rd_ok ? tx_mem[TX_AW'(tx_rd_pos)] : 8'd0;
  assign rx_rd_data = rx_rd_ok ? rx_mem[RX_AW'(rx_rd_pos)] : 8'd0;

endmodule

// ===== src/twi_buffered_transfer_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// twi_buffered_transfer_sequencer_core
// Byte buffering and sequencing above a TWI bus engine: master and slave
// transmit/receive, one result beat per input beat.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall   | op, index, data, address, count...
//  out_    | output    | out_valid / out_stall | action, drive byte, status, rx...
//
//  Two register stages: input register, then result register; one beat per
//  cycle sustained unless out_stall holds the result register.
//  State and stores are updated as a beat moves into the result register.
//  rst_n (synchronous) clears valids, counters, flags (stop_r set); stores kept.
//  out_stall backs up through the result register into in_stall in the same cycle.
// ----------------------------------------------------------------------------
module twi_buffered_transfer_sequencer_core
  import tbs_pkg::*;
#(
  parameter int unsigned TX_DEPTH = TBS_TX_DEPTH,
  parameter int unsigned RX_DEPTH = TBS_RX_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_op,
  input  logic [4:0] in_entry_index,
  input  logic [7:0] in_data_in,
  input  logic [6:0] in_target_address,
  input  logic       in_read_not_write,
  input  logic [7:0] in_byte_count,
  input  logic       in_send_stop,
  input  logic [4:0] in_bus_status,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_bus_action,
  output logic       out_drive_valid,
  output logic [7:0] out_drive_byte,
  output logic [1:0] out_call_status,
  output logic [7:0] out_rx_byte,
  output logic [5:0] out_rx_length,
  output logic [4:0] out_last_error,
  output logic       out_receive_done
);

  localparam logic [7:0] TX_LIM = 8'(TX_DEPTH);
  localparam logic [7:0] RX_LIM = 8'(RX_DEPTH);

  logic        s1_valid_r;
  tbs_item_t   s1_r;
  logic        out_valid_r;
  tbs_result_t res_r, res_nxt;
  logic        adv, fire;

  logic [5:0] tpos_r, tpos_nxt;
  logic [5:0] tlen_r, tlen_nxt;
  logic [5:0] rpos_r, rpos_nxt;
  logic [5:0] rlen_r, rlen_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic       stop_r, stop_nxt;
  logic [4:0] err_r, err_nxt;
  logic       done_r, done_nxt;

  tbs_wr_t    tx_wr, rx_wr;
  logic [5:0] tx_rd_pos;
  logic [7:0] tx_rd_data, rx_rd_data;
  logic       slave_restart;
  logic [5:0] inc_pos;
  logic [2:0] end_act;

  assign adv      = !out_valid_r || !out_stall;
  assign fire     = adv && s1_valid_r;
  assign in_stall = s1_valid_r && !adv;

  assign slave_restart = (s1_r.bus_status == ST_ST_SLA_ACK) ||
                         (s1_r.bus_status == ST_ST_ARB_SLA);
  assign tx_rd_pos     = slave_restart ? 6'd0 : tpos_r;
  assign end_act       = stop_r ? ACT_STOP : ACT_START_QUIET;

  tbs_stores #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_stores (
    .clk        (clk),
    .tx_wr      (tx_wr),
    .rx_wr      (rx_wr),
    .tx_rd_pos  (tx_rd_pos),
    .rx_rd_pos  ({1'b0, s1_r.entry_index}),
    .tx_rd_data (tx_rd_data),
    .rx_rd_data (rx_rd_data)
  );

  always_comb begin
    tpos_nxt = tpos_r;
    tlen_nxt = tlen_r;
    rpos_nxt = rpos_r;
    rlen_nxt = rlen_r;
    addr_nxt = addr_r;
    stop_nxt = stop_r;
    err_nxt  = err_r;
    done_nxt = done_r;
    inc_pos  = sat_inc(tx_rd_pos);

    tx_wr.en   = 1'b0;
    tx_wr.addr = {1'b0, s1_r.entry_index};
    tx_wr.data = s1_r.data_in;
    rx_wr.en   = 1'b0;
    rx_wr.addr = rpos_r;
    rx_wr.data = s1_r.data_in;

    res_nxt = '0;

    case (s1_r.op)
      OP_LOAD_TX: begin
        tx_wr.en = 1'b1;
      end
      OP_START: begin
        if (s1_r.byte_count > (s1_r.read_not_write ? RX_LIM : TX_LIM)) begin
          res_nxt.call_status = CS_OVF;
        end else begin
          addr_nxt = {s1_r.target_address, s1_r.read_not_write};
          if (s1_r.read_not_write) begin
            rlen_nxt = sat_len(s1_r.byte_count);
            rpos_nxt = 6'd0;
            done_nxt = 1'b0;
          end else begin
            tlen_nxt = sat_len(s1_r.byte_count);
            tpos_nxt = 6'd0;
          end
          if (!stop_r) begin
            res_nxt.drive_valid = 1'b1;
            res_nxt.drive_byte  = {s1_r.target_address, s1_r.read_not_write};
            res_nxt.bus_action  = ACT_CLEAR;
          end else begin
            res_nxt.bus_action  = ACT_START;
          end
          stop_nxt = s1_r.send_stop;
        end
      end
      OP_SLAVE_LEN: begin
        if (s1_r.byte_count > TX_LIM) begin
          res_nxt.call_status = CS_OVF;
        end else begin
          tpos_nxt = 6'd0;
          tlen_nxt = sat_len(s1_r.byte_count);
        end
      end
      OP_EVENT: begin
        case (s1_r.bus_status) inside
          ST_START, ST_REP_START: begin
            res_nxt.drive_valid = 1'b1;
            res_nxt.drive_byte  = addr_r;
            res_nxt.bus_action  = ACT_CLEAR;
          end
          ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
            if (tpos_r < tlen_r) begin
              res_nxt.drive_valid = 1'b1;
              res_nxt.drive_byte  = tx_rd_data;
              tpos_nxt            = inc_pos;
              res_nxt.bus_action  = ACT_CLEAR;
            end else begin
              res_nxt.bus_action  = end_act;
            end
          end
          ST_MT_SLA_NACK, ST_MT_DATA_NACK, ST_ARB_LOST, ST_MR_SLA_NACK: begin
            res_nxt.bus_action = ACT_STOP;
            err_nxt            = s1_r.bus_status;
            stop_nxt           = 1'b1;
          end
          ST_MR_SLA_ACK: begin
            res_nxt.bus_action = ACT_ACK;
          end
          ST_MR_DATA_ACK: begin
            rx_wr.en = 1'b1;
            rpos_nxt = sat_inc(rpos_r);
            res_nxt.bus_action = ({1'b0, rpos_nxt} + 7'd1 < {1'b0, rlen_r}) ?
                                 ACT_ACK : ACT_NACK;
          end
          ST_MR_DATA_NACK: begin
            rx_wr.en = 1'b1;
            rpos_nxt = sat_inc(rpos_r);
            done_nxt = 1'b1;
            res_nxt.bus_action = end_act;
          end
          ST_SR_SLA_ACK, ST_SR_ARB_SLA, ST_SR_GEN_ACK, ST_SR_ARB_GEN: begin
            rpos_nxt = 6'd0;
            rlen_nxt = 6'd0;
            res_nxt.bus_action = ACT_ACK;
          end
          ST_SR_DATA_ACK, ST_SR_GDAT_ACK: begin
            if ({2'b00, rpos_r} < RX_LIM) begin
              rx_wr.en = 1'b1;
              rpos_nxt = sat_inc(rpos_r);
              rlen_nxt = sat_inc(rlen_r);
              res_nxt.bus_action = ACT_ACK;
            end else begin
              res_nxt.bus_action = ACT_NACK;
            end
          end
          ST_SR_DATA_NACK, ST_SR_GDAT_NACK: begin
            rx_wr.en = 1'b1;
            rpos_nxt = sat_inc(rpos_r);
            rlen_nxt = sat_inc(rlen_r);
            res_nxt.bus_action = ACT_NACK;
          end
          ST_SR_STOP, ST_ST_DATA_NACK, ST_ST_LAST_ACK: begin
            res_nxt.bus_action = ACT_ACK;
          end
          ST_ST_SLA_ACK, ST_ST_ARB_SLA, ST_ST_DATA_ACK: begin
            res_nxt.drive_valid = 1'b1;
            res_nxt.drive_byte  = tx_rd_data;
            tpos_nxt            = inc_pos;
            res_nxt.bus_action  = (inc_pos < tlen_r) ? ACT_ACK : ACT_CLEAR;
          end
          ST_BUS_ERR: begin
            res_nxt.bus_action = ACT_STOP;
          end
          default: begin
            res_nxt.bus_action = ACT_NONE;
          end
        endcase
      end
      OP_READ_RX: begin
        res_nxt.rx_byte = rx_rd_data;
        if (rlen_r == 6'd0) begin
          res_nxt.call_status = CS_OVF;
        end else if (s1_r.byte_count > {2'b00, rlen_r}) begin
          res_nxt.call_status = CS_FEWER;
        end else if (s1_r.byte_count < {2'b00, rlen_r}) begin
          res_nxt.call_status = CS_MORE;
        end else begin
          res_nxt.call_status = CS_OK;
        end
      end
      default: begin
        res_nxt.call_status = CS_OK;
      end
    endcase

    tx_wr.en = tx_wr.en && fire;
    rx_wr.en = rx_wr.en && fire;

    res_nxt.rx_length    = rlen_nxt;
    res_nxt.last_error   = err_nxt;
    res_nxt.receive_done = done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tpos_r      <= 6'd0;
      tlen_r      <= 6'd0;
      rpos_r      <= 6'd0;
      rlen_r      <= 6'd0;
      addr_r      <= 8'd0;
      stop_r      <= 1'b1;
      err_r       <= 5'd0;
      done_r      <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire) begin
        tpos_r <= tpos_nxt;
        tlen_r <= tlen_nxt;
        rpos_r <= rpos_nxt;
        rlen_r <= rlen_nxt;
        addr_r <= addr_nxt;
        stop_r <= stop_nxt;
        err_r  <= err_nxt;
        done_r <= done_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r.op             <= in_op;
      s1_r.entry_index    <= in_entry_index;
      s1_r.data_in        <= in_data_in;
      s1_r.target_address <= in_target_address;
      s1_r.read_not_write <= in_read_not_write;
      s1_r.byte_count     <= in_byte_count;
      s1_r.send_stop      <= in_send_stop;
      s1_r.bus_status     <= in_bus_status;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bus_action   = res_r.bus_action;
  assign out_drive_valid  = res_r.drive_valid;
  assign out_drive_byte   = res_r.drive_byte;
  assign out_call_status  = res_r.call_status;
  assign out_rx_byte      = res_r.rx_byte;
  assign out_rx_length    = res_r.rx_length;
  assign out_last_error   = res_r.last_error;
  assign out_receive_done = res_r.receive_done;

endmodule
